[src/ray_sphere_intersect_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for ray_sphere_intersect
// Concurrent checks that can be switched out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

`ifndef ASSERT_OFF
// expression holds at every edge outside reset
`define RSI_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define RSI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RSI_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define RSI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[src/rsi_pkg.sv]
// ---------------------------------------------------------------------------
// rsi_pkg
// Widths and side-band types shared by the ray-sphere intersect pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package rsi_pkg;
   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 32;
   localparam int DIR_W     = 18;
   localparam int RAD_W     = 31;
   localparam int DIST_W    = 32;
   localparam int OC_W      = IN_W + 1;
   localparam int PROD_W    = OC_W + DIR_W;
   localparam int BRAW_W    = PROD_W + 2;
   localparam int B_W       = BRAW_W - FRAC_BITS;
   localparam int BL_W      = B_W / 2;
   localparam int BH_W      = B_W - BL_W;
   localparam int OCSQ_W    = 2 * OC_W + 2;
   localparam int RSQ_W     = 2 * RAD_W;
   localparam int BSQ_W     = 2 * B_W;
   localparam int DM_W      = ((BSQ_W > OCSQ_W) ? BSQ_W : OCSQ_W) + 1;
   localparam int D_W       = DM_W + 1;
   localparam int SQ_W      = (DM_W + 1) / 2;
   localparam int REM_W     = SQ_W + 3;
   localparam int T_W       = ((B_W > SQ_W) ? B_W : SQ_W) + 2;

   typedef struct packed {
      logic                  hit;
      logic signed [B_W-1:0] b;
   } side_type;
endpackage
`default_nettype wire

[src/rsi_if.sv]
// ---------------------------------------------------------------------------
// rsi_req_if / rsi_rsp_if
// Valid/ready channels carrying one ray-sphere test and its result.
// ---------------------------------------------------------------------------
`default_nettype none
interface rsi_req_if;
   import rsi_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [IN_W-1:0]    origin_x;
   logic signed [IN_W-1:0]    origin_y;
   logic signed [IN_W-1:0]    origin_z;
   logic signed [DIR_W-1:0]   dir_x;
   logic signed [DIR_W-1:0]   dir_y;
   logic signed [DIR_W-1:0]   dir_z;
   logic signed [IN_W-1:0]    center_x;
   logic signed [IN_W-1:0]    center_y;
   logic signed [IN_W-1:0]    center_z;
   logic        [RAD_W-1:0]   radius;
   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   center_x, center_y, center_z, radius, input ready);
   modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   center_x, center_y, center_z, radius, output ready);
endinterface

interface rsi_rsp_if;
   import rsi_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic signed [DIST_W-1:0]  distance;
   modport source (output valid, hit, distance, input ready);
   modport sink   (input valid, hit, distance, output ready);
endinterface
`default_nettype wire

[src/ray_sphere_intersect.sv]
// ---------------------------------------------------------------------------
// ray_sphere_intersect
// Fixed-point ray/sphere hit test returning the nearer hit distance.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one item: ray origin, unit direction, sphere centre and
//   radius, all in the same fixed-point units. rsp_chan returns one item per
//   request: hit and the nearer distance (0 on a miss), saturated to 32 bits.
//   Both are valid/ready; an item moves on an edge where both are high.
//   Pipeline: 5 arithmetic stages, SQ_W square-root stages (one root bit
//   each, 38 at the default format) and the output register, all between
//   acceptance and rsp valid. Throughput: one item per cycle unless rsp
//   holds off, set by the fully pipelined root with one stage per result bit.
//   Stalls: the whole pipeline advances together; when rsp is held off and
//   the output register is full, req_chan.ready drops and every stage holds.
//   Empty slots are not squeezed out while the output waits.
//   Reset: synchronous, clears all valid bits; no state beyond the pipe.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ray_sphere_intersect_macros.svh"
module ray_sphere_intersect (
   input  wire logic clock,
   input  wire logic reset,
   rsi_req_if.sink   req_chan,
   rsi_rsp_if.source rsp_chan
);
   import rsi_pkg::*;

   logic en;
   logic out_vld_ff;

   // advance when the output slot is free or being drained
   assign en = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // stage 1: oc = origin - centre
   logic                   s1_vld_ff;
   logic signed [OC_W-1:0] s1_ocx_ff, s1_ocy_ff, s1_ocz_ff;
   logic signed [DIR_W-1:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic [RAD_W-1:0]       s1_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ocx_ff <= OC_W'(req_chan.origin_x) - OC_W'(req_chan.center_x);
         s1_ocy_ff <= OC_W'(req_chan.origin_y) - OC_W'(req_chan.center_y);
         s1_ocz_ff <= OC_W'(req_chan.origin_z) - OC_W'(req_chan.center_z);
         s1_dx_ff  <= req_chan.dir_x;
         s1_dy_ff  <= req_chan.dir_y;
         s1_dz_ff  <= req_chan.dir_z;
         s1_r_ff   <= req_chan.radius;
      end
   end

   // stage 2: the seven products
   logic                     s2_vld_ff;
   logic signed [PROD_W-1:0] s2_px_ff, s2_py_ff, s2_pz_ff;
   logic [2*OC_W-1:0]        s2_qx_ff, s2_qy_ff, s2_qz_ff;
   logic [RSQ_W-1:0]         s2_rsq_ff;
   logic [OC_W-1:0]          magx_in, magy_in, magz_in;

   assign magx_in = s1_ocx_ff[OC_W-1] ? OC_W'(-s1_ocx_ff) : OC_W'(s1_ocx_ff);
   assign magy_in = s1_ocy_ff[OC_W-1] ? OC_W'(-s1_ocy_ff) : OC_W'(s1_ocy_ff);
   assign magz_in = s1_ocz_ff[OC_W-1] ? OC_W'(-s1_ocz_ff) : OC_W'(s1_ocz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_px_ff  <= PROD_W'(s1_dx_ff) * PROD_W'(s1_ocx_ff);
         s2_py_ff  <= PROD_W'(s1_dy_ff) * PROD_W'(s1_ocy_ff);
         s2_pz_ff  <= PROD_W'(s1_dz_ff) * PROD_W'(s1_ocz_ff);
         s2_qx_ff  <= (2*OC_W)'(magx_in) * (2*OC_W)'(magx_in);
         s2_qy_ff  <= (2*OC_W)'(magy_in) * (2*OC_W)'(magy_in);
         s2_qz_ff  <= (2*OC_W)'(magz_in) * (2*OC_W)'(magz_in);
         s2_rsq_ff <= RSQ_W'(s1_r_ff) * RSQ_W'(s1_r_ff);
      end
   end

   // stage 3: b = floor(dir.oc), oc.oc
   logic                     s3_vld_ff;
   logic signed [B_W-1:0]    s3_b_ff;
   logic [OCSQ_W-1:0]        s3_ocsq_ff;
   logic [RSQ_W-1:0]         s3_rsq_ff;
   logic signed [BRAW_W-1:0] braw_in;

   assign braw_in = BRAW_W'(s2_px_ff) + BRAW_W'(s2_py_ff) + BRAW_W'(s2_pz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // dropping low bits of two's complement is a floor
         s3_b_ff    <= braw_in[BRAW_W-1:FRAC_BITS];
         s3_ocsq_ff <= OCSQ_W'(s2_qx_ff) + OCSQ_W'(s2_qy_ff) + OCSQ_W'(s2_qz_ff);
         s3_rsq_ff  <= s2_rsq_ff;
      end
   end

   // stage 4: |b| squared as three half-width partial products
   logic                  s4_vld_ff;
   logic signed [B_W-1:0] s4_b_ff;
   logic [2*BH_W-1:0]     s4_hh_ff;
   logic [BH_W+BL_W-1:0]  s4_hl_ff;
   logic [2*BL_W-1:0]     s4_ll_ff;
   logic [OCSQ_W-1:0]     s4_ocsq_ff;
   logic [RSQ_W-1:0]      s4_rsq_ff;
   logic [B_W-1:0]        bmag_in;

   assign bmag_in = s3_b_ff[B_W-1] ? B_W'(-s3_b_ff) : B_W'(s3_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_hh_ff   <= (2*BH_W)'(bmag_in[B_W-1:BL_W]) * (2*BH_W)'(bmag_in[B_W-1:BL_W]);
         s4_hl_ff   <= (BH_W+BL_W)'(bmag_in[B_W-1:BL_W]) * (BH_W+BL_W)'(bmag_in[BL_W-1:0]);
         s4_ll_ff   <= (2*BL_W)'(bmag_in[BL_W-1:0]) * (2*BL_W)'(bmag_in[BL_W-1:0]);
         s4_b_ff    <= s3_b_ff;
         s4_ocsq_ff <= s3_ocsq_ff;
         s4_rsq_ff  <= s3_rsq_ff;
      end
   end

   // stage 5: discriminant d = b*b - oc.oc + r*r
   logic                  s5_vld_ff;
   logic [2*SQ_W-1:0]     s5_rad_ff;
   side_type              s5_side_ff;
   logic [BSQ_W-1:0]      bsq_in;
   logic signed [D_W-1:0] d_in;

   assign bsq_in = (BSQ_W'(s4_hh_ff) << (2*BL_W)) + (BSQ_W'(s4_hl_ff) << (BL_W+1))
                 + BSQ_W'(s4_ll_ff);
   assign d_in   = D_W'(bsq_in) - D_W'(s4_ocsq_ff) + D_W'(s4_rsq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_rad_ff       <= d_in[D_W-1] ? '0 : (2*SQ_W)'(d_in[DM_W-1:0]);
         s5_side_ff.hit  <= !d_in[D_W-1];
         s5_side_ff.b    <= s4_b_ff;
      end
   end

   // square root pipeline
   logic            sq_vld;
   logic [SQ_W-1:0] sq_root;
   side_type        sq_side;

   rsi_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_vld_ff),
      .in_rad    (s5_rad_ff),
      .in_side   (s5_side_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // output stage: t = -b - sqrt(d), saturated
   logic                     hit_ff;
   logic signed [DIST_W-1:0] dist_ff;
   logic signed [T_W-1:0]    t_in;
   logic signed [DIST_W-1:0] sat_in;

   assign t_in = -T_W'(sq_side.b) - T_W'({1'b0, sq_root});

   // limits held as signed so a negative t compares as negative
   always_comb begin
      if (t_in > $signed(T_W'({1'b0, {(DIST_W-1){1'b1}}}))) begin
         sat_in = {1'b0, {(DIST_W-1){1'b1}}};
      end else if (t_in < -$signed(T_W'({1'b1, {(DIST_W-1){1'b0}}}))) begin
         sat_in = {1'b1, {(DIST_W-1){1'b0}}};
      end else begin
         sat_in = t_in[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff  <= sq_side.hit;
         dist_ff <= sq_side.hit ? sat_in : '0;
      end
   end

   assign rsp_chan.valid    = out_vld_ff;
   assign rsp_chan.hit      = hit_ff;
   assign rsp_chan.distance = dist_ff;

   // checks
   `RSI_ASSERT_ALWAYS(a_miss_zero, clock, reset, !out_vld_ff || hit_ff || (dist_ff == '0))
   `RSI_ASSERT_ALWAYS(a_ready_rule, clock, reset,
      req_chan.ready == (!rsp_chan.valid || rsp_chan.ready))
   `RSI_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready,
      rsp_chan.valid && $stable(dist_ff) && $stable(hit_ff))
endmodule
`default_nettype wire

[src/rsi_sqrt.sv]
// ---------------------------------------------------------------------------
// rsi_sqrt
// Pipelined floor square root, one result bit per stage, side-band carried.
// ---------------------------------------------------------------------------
`default_nettype none
module rsi_sqrt (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [2*rsi_pkg::SQ_W-1:0] in_rad,
   input  wire rsi_pkg::side_type         in_side,
   output logic                           out_valid,
   output logic [rsi_pkg::SQ_W-1:0]       out_root,
   output rsi_pkg::side_type              out_side
);
   import rsi_pkg::*;

   logic [SQ_W:0]         vld_ff;
   logic [REM_W-1:0]      rem_ff  [SQ_W+1];
   logic [SQ_W-1:0]       root_ff [SQ_W+1];
   logic [2*SQ_W-1:0]     rad_ff  [SQ_W+1];
   side_type              side_ff [SQ_W+1];

   assign vld_ff[0]  = in_valid;
   assign rem_ff[0]  = '0;
   assign root_ff[0] = '0;
   assign rad_ff[0]  = in_rad;
   assign side_ff[0] = in_side;

   for (genvar k = 0; k < SQ_W; k++) begin : g_step
      logic [REM_W-1:0] cur_in;
      logic [REM_W-1:0] trial_in;
      logic             take_in;
      assign cur_in   = {rem_ff[k][REM_W-3:0], rad_ff[k][2*SQ_W-1 -: 2]};
      assign trial_in = {1'b0, root_ff[k], 2'b01};
      assign take_in  = (cur_in >= trial_in);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= take_in ? (cur_in - trial_in) : cur_in;
            root_ff[k+1] <= {root_ff[k][SQ_W-2:0], take_in};
            rad_ff[k+1]  <= {rad_ff[k][2*SQ_W-3:0], 2'b00};
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[SQ_W];
   assign out_root  = root_ff[SQ_W];
   assign out_side  = side_ff[SQ_W];
endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - ray_sphere_intersect testbench
// Drives ray/sphere items over the valid/ready request channel and checks
// every result against a hand-worked or in-bench fixed-point prediction.
// Directed rows come first, then random items under three idling regimes
// and one long receiver hold-off that backs the pipeline up.
// ---------------------------------------------------------------------------
module tb;
   import rsi_pkg::*;

   typedef struct {
      logic signed [IN_W-1:0]  ox, oy, oz;
      logic signed [DIR_W-1:0] dx, dy, dz;
      logic signed [IN_W-1:0]  cx, cy, cz;
      logic        [RAD_W-1:0] rad;
   } ray_item_type;

   typedef struct {
      logic                     hit;
      logic signed [DIST_W-1:0] distance;
   } hit_result_type;

   // directed row: item, plus a hand-worked result where one is obvious
   typedef struct {
      ray_item_type   item;
      bit             fixed;
      hit_result_type res;
   } dir_row_type;

   localparam int ONE       = 1 << FRAC_BITS;
   localparam int LATENCY   = SQ_W + 6;
   localparam int N_RANDOM  = 630;
   localparam int MAX_CYC   = 400000;

   logic clock;
   logic reset;

   rsi_req_if req ();
   rsi_rsp_if rsp ();

   ray_sphere_intersect u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   hit_result_type pending_hits[$];
   int          mismatches;
   int          n_sent;
   int          n_checked;
   int          n_hits;
   int          n_sat;
   int          cycles;
   int          tx_idle;          // percent of cycles the sender idles
   int          rx_idle;          // percent of cycles the receiver idles
   bit          hold_go;          // ask the receiver for one long hold-off
   int          hold_len;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor: oc, floored b, discriminant at 130 bits, floor sqrt,
   //   then a distance saturated to 32 bits.
   // ------------------------------------------------------------------
   function automatic hit_result_type hit_distance(ray_item_type it);
      logic signed [63:0]  ocx, ocy, ocz;
      logic signed [63:0]  braw, b, t;
      logic signed [129:0] disc, rr, bw, ox2, oy2, oz2;
      logic        [63:0]  root, cand;
      logic        [129:0] csq;
      hit_result_type      r;
      ocx  = 64'(it.ox) - 64'(it.cx);
      ocy  = 64'(it.oy) - 64'(it.cy);
      ocz  = 64'(it.oz) - 64'(it.cz);
      braw = ocx * 64'(it.dx) + ocy * 64'(it.dy) + ocz * 64'(it.dz);
      b    = braw >>> FRAC_BITS;      // arithmetic shift = floor
      bw   = 130'(b);
      ox2  = 130'(ocx);
      oy2  = 130'(ocy);
      oz2  = 130'(ocz);
      rr   = $signed({99'd0, it.rad});
      disc = bw * bw - (ox2 * ox2 + oy2 * oy2 + oz2 * oz2) + rr * rr;
      if (disc < 0) begin
         r.hit      = 1'b0;
         r.distance = '0;
         return r;
      end
      root = '0;
      for (int k = 63; k >= 0; k--) begin
         cand = root | (64'd1 << k);
         csq  = 130'(cand) * 130'(cand);
         if (csq <= $unsigned(disc)) root = cand;
      end
      t = -b - $signed(root);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      r.hit      = 1'b1;
      r.distance = t[DIST_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, n_checked);
   endtask

   // one item: random gaps, then hold valid until the block takes it
   task automatic send_item(ray_item_type it, bit fixed, hit_result_type res);
      while ($urandom_range(99) < tx_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.origin_x <= it.ox;
      req.origin_y <= it.oy;
      req.origin_z <= it.oz;
      req.dir_x    <= it.dx;
      req.dir_y    <= it.dy;
      req.dir_z    <= it.dz;
      req.center_x <= it.cx;
      req.center_y <= it.cy;
      req.center_z <= it.cz;
      req.radius   <= it.rad;
      do @(posedge clock); while (!req.ready);
      pending_hits.push_back(fixed ? res : hit_distance(it));
      n_sent++;
   endtask

   function automatic ray_item_type make_ray(int kind);
      ray_item_type it;
      int           span;
      if (kind == 0) begin
         // full-range noise, every bit free
         it.ox = $urandom; it.oy = $urandom; it.oz = $urandom;
         it.cx = $urandom; it.cy = $urandom; it.cz = $urandom;
         it.dx = DIR_W'($urandom); it.dy = DIR_W'($urandom); it.dz = DIR_W'($urandom);
         it.rad = RAD_W'($urandom);
      end else begin
         // scene-like: unit-ish direction, sphere near the origin
         span  = (kind == 1) ? 64 * ONE : 30000 * ONE;
         it.ox = $signed($urandom_range(2 * span)) - span;
         it.oy = $signed($urandom_range(2 * span)) - span;
         it.oz = $signed($urandom_range(2 * span)) - span;
         it.cx = it.ox + $signed($urandom_range(2 * span)) - span;
         it.cy = it.oy + $signed($urandom_range(2 * span)) - span;
         it.cz = it.oz + $signed($urandom_range(2 * span)) - span;
         it.dx = DIR_W'($signed($urandom_range(2 * ONE)) - ONE);
         it.dy = DIR_W'($signed($urandom_range(2 * ONE)) - ONE);
         it.dz = DIR_W'($signed($urandom_range(2 * ONE)) - ONE);
         it.rad = RAD_W'($urandom_range(span));
      end
      return it;
   endfunction

   function automatic dir_row_type row(ray_item_type it, bit fixed, logic hit, int distance);
      dir_row_type r;
      r.item         = it;
      r.fixed        = fixed;
      r.res.hit      = hit;
      r.res.distance = distance;
      return r;
   endfunction

   function automatic ray_item_type ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                        int cx, int cy, int cz, int rad);
      ray_item_type it;
      it.ox = ox; it.oy = oy; it.oz = oz;
      it.dx = DIR_W'(dx); it.dy = DIR_W'(dy); it.dz = DIR_W'(dz);
      it.cx = cx; it.cy = cy; it.cz = cz;
      it.rad = RAD_W'(rad);
      return it;
   endfunction

   // ------------------------------------------------------------------
   // Receiver: random ready, plus a long hold-off on request
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_len  <= 0;
      end else if (hold_len > 0) begin
         rsp.ready <= 1'b0;
         hold_len  <= hold_len - 1;
      end else if (hold_go) begin
         rsp.ready <= 1'b0;
         hold_len  <= 300;
      end else begin
         rsp.ready <= ($urandom_range(99) >= rx_idle);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_hits.size() == 0) begin
            report_mismatch("unexpected result", rsp.distance, 0);
         end else begin
            hit_result_type w;
            w = pending_hits.pop_front();
            if (rsp.hit !== w.hit) report_mismatch("hit", rsp.hit, w.hit);
            if (rsp.distance !== w.distance)
               report_mismatch("distance", rsp.distance, w.distance);
            if (w.hit) n_hits++;
            if (w.distance == 32'sh7fffffff || w.distance == 32'sh80000000) n_sat++;
         end
         n_checked++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYC) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_hits.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      dir_row_type    rows[$];
      hit_result_type none;
      int             wait_cyc;
      none.hit      = 1'b0;
      none.distance = '0;

      cycles       = 0;
      mismatches   = 0;
      n_sent       = 0;
      n_checked    = 0;
      n_hits       = 0;
      n_sat        = 0;
      hold_go      = 1'b0;
      tx_idle      = 28;
      rx_idle      = 58;
      req.valid    = 1'b0;
      req.origin_x = '0; req.origin_y = '0; req.origin_z = '0;
      req.dir_x    = '0; req.dir_y    = '0; req.dir_z    = '0;
      req.center_x = '0; req.center_y = '0; req.center_z = '0;
      req.radius   = '0;
      rsp.ready    = 1'b0;
      reset        = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // all zero: degenerate tangent, distance 0
      rows.push_back(row(ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1'b1, 0));
      // clear miss: centre ten units off a ray along x
      rows.push_back(row(ray(0, 10 * ONE, 0, ONE, 0, 0, 0, 0, 0, ONE), 1, 1'b0, 0));
      // tangent ray: d is zero, distance is -b = 0
      rows.push_back(row(ray(0, ONE, 0, ONE, 0, 0, 0, 0, 0, ONE), 1, 1'b1, 0));
      // positive saturation: b = -(2^32 - 1), d zero
      rows.push_back(row(ray(32'sh80000000, 0, 0, ONE, 0, 0, 32'sh7fffffff, 0, 0, 0),
                         1, 1'b1, 32'sh7fffffff));
      // negative saturation: b = +(2^32 - 1), d zero
      rows.push_back(row(ray(32'sh80000000, 0, 0, -ONE, 0, 0, 32'sh7fffffff, 0, 0, 0),
                         1, 1'b1, 32'sh80000000));
      // ordinary front hit, sphere ahead along z
      rows.push_back(row(ray(0, 0, 0, 0, 0, ONE, 0, 0, 10 * ONE, 2 * ONE), 0, 0, 0));
      // origin inside the sphere
      rows.push_back(row(ray(ONE, ONE, 0, 0, ONE, 0, 0, 0, 0, 5 * ONE), 0, 0, 0));
      // direction beyond unit length, both 18-bit ends
      rows.push_back(row(ray(0, 0, 0, 131071, -131072, 131071, ONE, 2 * ONE, 3 * ONE,
                             4 * ONE), 0, 0, 0));
      rows.push_back(row(ray(-7 * ONE, 3, 9, -131072, 131071, -131072, 5, -2, ONE,
                             ONE), 0, 0, 0));
      // non-unit direction with odd fraction bits, b floors to zero
      rows.push_back(row(ray(3, 0, 0, 40001, 12345, -1, 0, 7, 0, 9 * ONE), 0, 0, 0));
      // largest radius, extreme positions
      rows.push_back(row(ray(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, ONE, ONE, ONE,
                             32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'h7fffffff),
                         0, 0, 0));
      rows.push_back(row(ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, 32'h7fffffff), 0, 0, 0));
      rows.push_back(row(ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0,
                             32'sh80000000, 32'sh80000000, 32'sh80000000, 32'h7fffffff),
                         0, 0, 0));
      // sphere behind the ray: hit with negative distance
      rows.push_back(row(ray(0, 0, 20 * ONE, 0, 0, ONE, 0, 0, 0, ONE), 0, 0, 0));

      foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].res);

      // random part in three idling regimes
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 3) begin
            tx_idle = 58;
            rx_idle = 28;
         end
         if (i == 2 * N_RANDOM / 3) begin
            tx_idle = 0;
            rx_idle = 0;
            // long hold-off while the sender keeps offering: pipe fills up
            req.valid <= 1'b0;
            hold_go   <= 1'b1;
            @(posedge clock);
            hold_go   <= 1'b0;
         end
         send_item(make_ray($urandom_range(3) == 0 ? 0 : $urandom_range(1, 2)), 0, none);
      end
      req.valid <= 1'b0;

      wait_cyc = 0;
      while (pending_hits.size() != 0) @(posedge clock);
      while (wait_cyc < 2 * LATENCY) begin
         @(posedge clock);
         wait_cyc++;
      end

      $display("sent %0d items, checked %0d results: %0d hits, %0d saturated",
               n_sent, n_checked, n_hits, n_sat);
      $display("idling swapped between sides, one 300-cycle output hold-off");
      if (mismatches == 0 && pending_hits.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+src
src/rsi_pkg.sv
src/rsi_if.sv
src/rsi_sqrt.sv
src/ray_sphere_intersect.sv
dv/tb.sv
